// ===== hdl/ambisonic_speaker_decoder_top_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef AMBISONIC_SPEAKER_DECODER_TOP_DEFINES_SVH
`define AMBISONIC_SPEAKER_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication within the same clock edge.
`define ASD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition now, consequence on the next edge.
`define ASD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define ASD_ASSERT(lbl, clk, rstn, prop, msg)
`define ASD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// ===== hdl/asd_pkg.sv =====
package asd_pkg;

    typedef logic signed [16:0] coef_t;
    typedef logic signed [17:0] gain_t;

    // classification of one transaction, passed front to back
    typedef struct packed {
        logic [6:0] first;   // first decode row
        logic [4:0] count;   // speakers to emit
        logic       is_3d;   // Z channel used
    } asd_cls_t;

    // register indexes
    localparam logic [0:0] REG_LAYOUT = 1'b0;
    localparam logic [0:0] REG_NORM   = 1'b1;

    // layout codes
    localparam logic [3:0] LAY_MONO     = 4'd0;
    localparam logic [3:0] LAY_STEREO   = 4'd1;
    localparam logic [3:0] LAY_TRIANGLE = 4'd2;
    localparam logic [3:0] LAY_SQUARE   = 4'd3;
    localparam logic [3:0] LAY_PENTAGON = 4'd4;
    localparam logic [3:0] LAY_HEXAGON  = 4'd5;
    localparam logic [3:0] LAY_HEPTAGON = 4'd6;
    localparam logic [3:0] LAY_OCTAGON  = 4'd7;
    localparam logic [3:0] LAY_TETRA    = 4'd8;
    localparam logic [3:0] LAY_OCTA     = 4'd9;
    localparam logic [3:0] LAY_CUBE     = 4'd10;
    localparam logic [3:0] LAY_DODECA   = 4'd11;
    localparam logic [3:0] LAY_ICOSA    = 4'd12;

    // normalisation codes
    localparam logic [1:0] NORM_N3D  = 2'd0;
    localparam logic [1:0] NORM_SN3D = 2'd1;
    localparam logic [1:0] NORM_FUMA = 2'd2;

    // Q2.16 gains
    localparam gain_t GAIN_ONE   = 18'sd65536;
    localparam gain_t GAIN_SQRT2 = 18'sd92682;
    localparam gain_t GAIN_SQRT3 = 18'sd113512;

    localparam int          Q_DEPTH  = 2;   // power of two
    localparam int          NUM_ROWS = 80;
    localparam logic [6:0]  LAST_ROW = 7'd79;

    // decode matrix, columns W X Y Z, Q1.16
    localparam coef_t DEC_ROWS [NUM_ROWS][4] = '{
        // mono
        '{17'sd14520, 17'sd0, 17'sd0, 17'sd0},
        // triangle
        '{17'sd11689, 17'sd21335, 17'sd12317, 17'sd0},
        '{17'sd11689, 17'sd0, -17'sd24636, 17'sd0},
        '{17'sd11689, -17'sd21335, 17'sd12317, 17'sd0},
        // square
        '{17'sd25813, 17'sd12249, 17'sd12249, 17'sd0},
        '{17'sd25813, -17'sd12249, 17'sd12249, 17'sd0},
        '{17'sd25813, -17'sd12249, -17'sd12249, 17'sd0},
        '{17'sd25813, 17'sd12249, -17'sd12249, 17'sd0},
        // pentagon
        '{17'sd13235, 17'sd0, 17'sd21902, 17'sd0},
        '{17'sd7442, 17'sd19012, 17'sd2743, 17'sd0},
        '{17'sd12880, -17'sd5238, -17'sd22795, 17'sd0},
        '{17'sd12880, 17'sd5238, -17'sd22795, 17'sd0},
        '{17'sd12880, -17'sd19012, 17'sd2743, 17'sd0},
        // hexagon
        '{17'sd17209, 17'sd0, 17'sd20530, 17'sd0},
        '{17'sd17209, 17'sd17779, 17'sd10265, 17'sd0},
        '{17'sd17209, 17'sd17779, -17'sd10265, 17'sd0},
        '{17'sd17209, 17'sd0, -17'sd20530, 17'sd0},
        '{17'sd17209, -17'sd17779, -17'sd10265, 17'sd0},
        '{17'sd17209, -17'sd17779, 17'sd10265, 17'sd0},
        // heptagon
        '{17'sd14746, 17'sd0, 17'sd17594, 17'sd0},
        '{17'sd14750, 17'sd13755, 17'sd10971, 17'sd0},
        '{17'sd14750, 17'sd17157, -17'sd3912, 17'sd0},
        '{17'sd14753, 17'sd7636, -17'sd15856, 17'sd0},
        '{17'sd14753, -17'sd7636, -17'sd15856, 17'sd0},
        '{17'sd14750, -17'sd17157, -17'sd3912, 17'sd0},
        '{17'sd14750, -17'sd13755, 17'sd10971, 17'sd0},
        // octagon
        '{17'sd12907, 17'sd5892, 17'sd14225, 17'sd0},
        '{17'sd12907, 17'sd14225, 17'sd5892, 17'sd0},
        '{17'sd12907, 17'sd14225, -17'sd5892, 17'sd0},
        '{17'sd12907, 17'sd5892, -17'sd14225, 17'sd0},
        '{17'sd12907, -17'sd5892, -17'sd14225, 17'sd0},
        '{17'sd12907, -17'sd14225, -17'sd5892, 17'sd0},
        '{17'sd12907, -17'sd14225, 17'sd5892, 17'sd0},
        '{17'sd12907, -17'sd5892, 17'sd14225, 17'sd0},
        // octahedron
        '{17'sd30036, 17'sd27241, 17'sd0, 17'sd8640},
        '{17'sd62891, 17'sd27241, 17'sd0, -17'sd24049},
        '{17'sd30036, -17'sd27241, 17'sd0, 17'sd8640},
        '{17'sd62891, -17'sd27241, 17'sd0, -17'sd24049},
        '{17'sd23232, 17'sd0, 17'sd0, 17'sd15409},
        '{17'sd23232, 17'sd0, 17'sd0, 17'sd15409},
        // cube
        '{17'sd9351, 17'sd9771, 17'sd18751, 17'sd9771},
        '{17'sd9351, 17'sd9771, -17'sd18751, 17'sd9771},
        '{17'sd9351, -17'sd9771, 17'sd18751, 17'sd9771},
        '{17'sd9351, -17'sd9771, -17'sd18751, 17'sd9771},
        '{17'sd9351, 17'sd9771, 17'sd18751, -17'sd9771},
        '{17'sd9351, 17'sd9771, -17'sd18751, -17'sd9771},
        '{17'sd9351, -17'sd9771, 17'sd18751, -17'sd9771},
        '{17'sd9351, -17'sd9771, -17'sd18751, -17'sd9771},
        // dodecahedron
        '{17'sd11616, 17'sd0, 17'sd0, 17'sd9448},
        '{17'sd11616, 17'sd5553, 17'sd0, 17'sd7643},
        '{17'sd11616, 17'sd8985, 17'sd0, 17'sd2919},
        '{17'sd11616, 17'sd8985, 17'sd0, -17'sd2919},
        '{17'sd11616, 17'sd5553, 17'sd0, -17'sd7643},
        '{17'sd11616, 17'sd0, 17'sd0, -17'sd9448},
        '{17'sd11616, -17'sd5553, 17'sd0, 17'sd7643},
        '{17'sd11616, -17'sd8985, 17'sd0, 17'sd2919},
        '{17'sd11616, -17'sd8985, 17'sd0, -17'sd2919},
        '{17'sd11616, -17'sd5553, 17'sd0, -17'sd7643},
        '{17'sd11616, 17'sd0, 17'sd12685, 17'sd7505},
        '{17'sd11616, 17'sd7138, 17'sd12685, 17'sd2319},
        '{17'sd11616, 17'sd4411, 17'sd12685, -17'sd6072},
        '{17'sd11616, -17'sd7138, 17'sd12685, 17'sd2319},
        '{17'sd11616, -17'sd4411, 17'sd12685, -17'sd6072},
        '{17'sd11616, 17'sd4411, -17'sd12685, 17'sd6072},
        '{17'sd11616, 17'sd7138, -17'sd12685, -17'sd2319},
        '{17'sd11616, 17'sd0, -17'sd12685, -17'sd7505},
        '{17'sd11616, -17'sd7138, -17'sd12685, -17'sd2319},
        '{17'sd11616, -17'sd4411, -17'sd12685, 17'sd6072},
        // icosahedron
        '{17'sd11957, 17'sd0, 17'sd0, 17'sd14731},
        '{17'sd11957, 17'sd0, 17'sd0, 17'sd14731},
        '{17'sd14978, 17'sd0, 17'sd11340, 17'sd10024},
        '{17'sd18827, 17'sd19974, 17'sd11340, 17'sd1062},
        '{17'sd18827, -17'sd19974, 17'sd11340, 17'sd1062},
        '{17'sd26114, 17'sd12344, 17'sd11340, -17'sd13440},
        '{17'sd26114, -17'sd12344, 17'sd11340, -17'sd13440},
        '{17'sd14978, 17'sd0, -17'sd11340, 17'sd10024},
        '{17'sd18827, 17'sd19974, -17'sd11340, 17'sd1062},
        '{17'sd18827, -17'sd19974, -17'sd11340, 17'sd1062},
        '{17'sd26114, 17'sd12344, -17'sd11340, -17'sd13440},
        '{17'sd26114, -17'sd12344, -17'sd11340, -17'sd13440}
    };

    // first row, table speaker count and Z use of a layout
    function automatic asd_cls_t lay_info(input logic [3:0] lay);
        asd_cls_t r;
        unique case (lay)
            LAY_MONO:     r = '{first: 7'd0,  count: 5'd1,  is_3d: 1'b0};
            LAY_TRIANGLE: r = '{first: 7'd1,  count: 5'd3,  is_3d: 1'b0};
            LAY_SQUARE:   r = '{first: 7'd4,  count: 5'd4,  is_3d: 1'b0};
            LAY_PENTAGON: r = '{first: 7'd8,  count: 5'd5,  is_3d: 1'b0};
            LAY_HEXAGON:  r = '{first: 7'd13, count: 5'd6,  is_3d: 1'b0};
            LAY_HEPTAGON: r = '{first: 7'd19, count: 5'd7,  is_3d: 1'b0};
            LAY_OCTAGON:  r = '{first: 7'd26, count: 5'd8,  is_3d: 1'b0};
            LAY_OCTA:     r = '{first: 7'd34, count: 5'd6,  is_3d: 1'b0};
            LAY_CUBE:     r = '{first: 7'd40, count: 5'd8,  is_3d: 1'b1};
            LAY_DODECA:   r = '{first: 7'd48, count: 5'd20, is_3d: 1'b1};
            LAY_ICOSA:    r = '{first: 7'd68, count: 5'd12, is_3d: 1'b1};
            // stereo, tetrahedron and unused codes: nothing emitted
            default:      r = '{first: 7'd0,  count: 5'd0,  is_3d: 1'b0};
        endcase
        return r;
    endfunction

    // input gain per normalisation and channel (0 W, 1 X, 2 Y, 3 Z)
    function automatic gain_t norm_gain(input logic [1:0] nrm, input logic [1:0] ch);
        gain_t g;
        case (nrm)
            NORM_SN3D: g = (ch == 2'd0) ? GAIN_ONE : GAIN_SQRT3;
            NORM_FUMA: g = (ch == 2'd0) ? GAIN_SQRT2 : GAIN_SQRT3;
            default:   g = GAIN_ONE;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/asd_front.sv =====
module asd_front #(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_SPEAKERS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [3:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [4*SAMPLE_BITS-1:0]      s_samples,   // W, X, Y, Z from bit 0
    input  logic                          q_full,
    output logic                          q_push,
    output asd_pkg::asd_cls_t             q_cls,
    output logic [4*(SAMPLE_BITS+1)-1:0]  q_data       // scaled W, X, Y, Z
);
    import asd_pkg::*;

    localparam int SW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + 18;

    logic [3:0] layout_reg;
    logic [1:0] norm_reg;
    asd_cls_t   tab;
    logic       accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= LAY_SQUARE;
            norm_reg   <= NORM_N3D;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LAYOUT: layout_reg <= cfg_wdata;
                REG_NORM:   norm_reg   <= cfg_wdata[1:0];
                default:    ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        tab   = lay_info(layout_reg);
        q_cls = tab;
        if (tab.count > 5'(MAX_SPEAKERS))
            q_cls.count = 5'(MAX_SPEAKERS);
    end

    // empty layouts never enter the queue
    assign q_push = accept && (q_cls.count != 5'd0);

    always_comb begin
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] rnd;
        q_data = '0;
        for (int c = 0; c < 4; c++) begin
            prod = $signed(s_samples[c*SAMPLE_BITS +: SAMPLE_BITS]) * norm_gain(norm_reg, 2'(c));
            rnd  = prod + PW'(32'sd32768);
            q_data[c*SW +: SW] = rnd[SW+15:16];
        end
    end

endmodule

// ===== hdl/asd_queue.sv =====
`include "ambisonic_speaker_decoder_top_defines.svh"

module asd_queue #(
    parameter int W = 100
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  asd_pkg::asd_cls_t in_cls,
    input  logic [W-1:0]      in_data,
    output logic              full,
    output logic              out_valid,
    output asd_pkg::asd_cls_t out_cls,
    output logic [W-1:0]      out_data,
    input  logic              pop
);
    import asd_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    // slot 0 is the head; slots move down one place on each pop
    asd_cls_t         slot_cls_reg  [Q_DEPTH];
    logic [W-1:0]     slot_data_reg [Q_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] wr_slot;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign do_pop    = pop && out_valid;
    // slot that a pushed transaction lands in this cycle
    assign wr_slot   = do_pop ? cnt_reg - 1'b1 : cnt_reg;
    assign out_cls   = slot_cls_reg[0];
    assign out_data  = slot_data_reg[0];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Q_DEPTH - 1; i++) begin
            if (push && (wr_slot == CNT_W'(i))) begin
                slot_cls_reg[i]  <= in_cls;
                slot_data_reg[i] <= in_data;
            end else if (do_pop) begin
                slot_cls_reg[i]  <= slot_cls_reg[i + 1];
                slot_data_reg[i] <= slot_data_reg[i + 1];
            end
        end
        if (push && (wr_slot == CNT_W'(Q_DEPTH - 1))) begin
            slot_cls_reg[Q_DEPTH - 1]  <= in_cls;
            slot_data_reg[Q_DEPTH - 1] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `ASD_ASSERT(a_no_overflow, aclk, aresetn, full |-> !push, "push into full queue")

endmodule

// ===== hdl/asd_back.sv =====
`include "ambisonic_speaker_decoder_top_defines.svh"

module asd_back #(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_SPEAKERS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  asd_pkg::asd_cls_t             q_cls,
    input  logic [4*(SAMPLE_BITS+1)-1:0]  q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4:0]                    m_index,
    output logic [SAMPLE_BITS-1:0]        m_sample,
    output logic                          m_tlast
);
    import asd_pkg::*;

    localparam int SW    = SAMPLE_BITS + 1;
    localparam int PW    = SW + 17;
    localparam int ACC_W = PW + 2;
    localparam int SHW   = ACC_W - 16;
    localparam logic signed [SHW-1:0] MAXV =
        {{(SHW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SHW-1:0] MINV = ~MAXV;

    logic [4:0]  k_reg;
    logic [4:0]  k_next;
    logic        en;
    logic        issue;
    logic        is_last;
    logic [6:0]  row_sum;
    logic [6:0]  row;
    coef_t       coef [4];

    logic                 p1_valid_reg;
    logic [4:0]           p1_idx_reg;
    logic                 p1_last_reg;
    logic signed [PW-1:0] p1_prod_reg [4];

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    logic signed [SHW-1:0]   sh;
    logic [SAMPLE_BITS-1:0]  sat;

    logic                   m_valid_reg;
    logic [4:0]             m_idx_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    logic                   m_last_reg;

    // whole back pipeline moves when the output slot is free
    assign en      = !m_valid_reg || m_tready;
    assign issue   = en && q_valid;
    assign is_last = (k_reg == q_cls.count - 5'd1);
    assign q_pop   = issue && is_last;
    assign k_next  = is_last ? 5'd0 : k_reg + 5'd1;

    always_comb begin
        row_sum = q_cls.first + {2'b00, k_reg};
        row     = (row_sum > LAST_ROW) ? LAST_ROW : row_sum;
        for (int c = 0; c < 4; c++)
            coef[c] = DEC_ROWS[row][c];
        if (!q_cls.is_3d)
            coef[3] = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            k_reg <= '0;
        else if (issue)
            k_reg <= k_next;
    end

    // stage 1: four channel products
    always_ff @(posedge aclk) begin
        if (!aresetn)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= issue;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_idx_reg  <= k_reg;
            p1_last_reg <= is_last;
            for (int c = 0; c < 4; c++)
                p1_prod_reg[c] <= coef[c] * $signed(q_data[c*SW +: SW]);
        end
    end

    // stage 2: sum, round, saturate
    always_comb begin
        acc = '0;
        for (int c = 0; c < 4; c++)
            acc = acc + ACC_W'(p1_prod_reg[c]);
        rnd = acc + ACC_W'(32'sd32768);
        sh  = rnd[ACC_W-1:16];
        if (sh > MAXV)
            sat = MAXV[SAMPLE_BITS-1:0];
        else if (sh < MINV)
            sat = MINV[SAMPLE_BITS-1:0];
        else
            sat = sh[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_idx_reg    <= p1_idx_reg;
            m_sample_reg <= sat;
            m_last_reg   <= p1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_index  = m_idx_reg;
    assign m_sample = m_sample_reg;
    assign m_tlast  = m_last_reg;

    `ASD_ASSERT(a_k_in_range, aclk, aresetn, q_valid |-> k_reg < q_cls.count, "speaker count overrun")
    `ASD_ASSERT_NEXT(a_k_wraps, aclk, aresetn, q_pop, k_reg == 5'd0, "index not rewound after last")
    `ASD_ASSERT(a_out_idx, aclk, aresetn, m_valid_reg |-> m_idx_reg < 5'(MAX_SPEAKERS), "index beyond speaker limit")

endmodule

// ===== hdl/ambisonic_speaker_decoder_top.sv =====
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   tdata: w, x, y, z samples
// m_       out  m_tvalid/m_tready   tdata: speaker_index, speaker_sample; tlast: last_speaker
// cfg_     in   cfg_wr_en           cfg_index, cfg_wdata (no handshake back)
//
// One result per speaker per cycle while the result port is not stalled, set by
// the back end issuing one decode row each cycle.
// From input to first result the data passes the queue, the product stage and the output register.
// Layouts that emit nothing are accepted at the input and never reach the queue.
// Synchronous active-low reset clears the queue, valids, speaker counter and
// returns the registers to square layout, N3D normalisation.
// The two-entry queue lets input transactions land while the result port stalls.
module ambisonic_speaker_decoder_top #(
    parameter int MAX_SPEAKERS = 20,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration: index 0 speaker_layout, 1 input_normalisation
    input  logic                                     cfg_wr_en,
    input  logic [0:0]                               cfg_index,
    input  logic [3:0]                               cfg_wdata,
    // input stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // w_sample, x_sample, y_sample, z_sample, zero padding
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    // result stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // speaker_index[4:0], speaker_sample, zero padding
    output logic [((5+SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                     m_tlast
);
    import asd_pkg::*;

    localparam int OUT_W = ((5 + SAMPLE_BITS + 7) / 8) * 8;
    localparam int QW    = 4 * (SAMPLE_BITS + 1);

    logic                   q_full;
    logic                   q_push;
    asd_cls_t               q_in_cls;
    logic [QW-1:0]          q_in_data;
    logic                   q_valid;
    asd_cls_t               q_out_cls;
    logic [QW-1:0]          q_out_data;
    logic                   q_pop;
    logic [4:0]             m_index;
    logic [SAMPLE_BITS-1:0] m_sample;

    // front: config registers, layout lookup, input gains
    asd_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SPEAKERS (MAX_SPEAKERS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_samples (s_tdata[4*SAMPLE_BITS-1:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cls     (q_in_cls),
        .q_data    (q_in_data)
    );

    // decouples the input side from result back-pressure
    asd_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_cls    (q_in_cls),
        .in_data   (q_in_data),
        .full      (q_full),
        .out_valid (q_valid),
        .out_cls   (q_out_cls),
        .out_data  (q_out_data),
        .pop       (q_pop)
    );

    // back: walks the speakers of the head transaction, dot product per speaker
    asd_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SPEAKERS (MAX_SPEAKERS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cls    (q_out_cls),
        .q_data   (q_out_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_index  (m_index),
        .m_sample (m_sample),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = OUT_W'({m_sample, m_index});

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Bench for the first-order ambisonic speaker decoder.
// A B-format transaction goes in and one transaction per speaker of the
// selected layout comes out. The bench keeps its own copy of the decode
// matrix and the input gains. For each accepted input it queues the speaker
// results that it works out, and the checker compares every result
// transaction against the oldest entry in that queue.
module testbench;
    import asd_pkg::*;

    localparam int SMP_W         = 24;
    localparam int MAX_SPK       = 20;
    localparam int RANDOM_ITEMS  = 300;
    localparam int IDLE_LIMIT    = 5000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 8;     // margin for the pipeline to drain

    // codes with no name in the package
    localparam logic [3:0] LAY_SPARE_LO = 4'd13;
    localparam logic [3:0] LAY_SPARE_HI = 4'd15;
    localparam logic [1:0] NORM_SPARE   = 2'd3;

    typedef logic signed [SMP_W-1:0] smp_t;
    // packed so that w sits in the lowest bits of s_tdata
    typedef struct packed {
        smp_t z;
        smp_t y;
        smp_t x;
        smp_t w;
    } bformat_t;
    typedef struct packed {
        logic [4:0] idx;
        smp_t       smp;
        logic       last;
    } spk_out_t;

    localparam smp_t SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam smp_t SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    // per layout code: first matrix row, speakers emitted, channels used
    localparam int ROW_FIRST [16] = '{0, 0, 1, 4, 8, 13, 19, 26, 34, 34, 40, 48, 68, 0, 0, 0};
    localparam int ROW_COUNT [16] = '{1, 0, 3, 4, 5, 6, 7, 8, 0, 6, 8, 20, 12, 0, 0, 0};
    localparam int CHAN_USED [16] = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 3, 3, 3};

    // Q2.16 input gains per normalisation code, channels W X Y Z
    localparam longint IN_GAIN [4][4] = '{
        '{65536, 65536,  65536,  65536},
        '{65536, 113512, 113512, 113512},
        '{92682, 113512, 113512, 113512},
        '{65536, 65536,  65536,  65536}
    };

    // decode matrix, Q1.16, columns W X Y Z
    localparam int COEF [80][4] = '{
        '{14520, 0, 0, 0},
        '{11689, 21335, 12317, 0}, '{11689, 0, -24636, 0}, '{11689, -21335, 12317, 0},
        '{25813, 12249, 12249, 0}, '{25813, -12249, 12249, 0},
        '{25813, -12249, -12249, 0}, '{25813, 12249, -12249, 0},
        '{13235, 0, 21902, 0}, '{7442, 19012, 2743, 0}, '{12880, -5238, -22795, 0},
        '{12880, 5238, -22795, 0}, '{12880, -19012, 2743, 0},
        '{17209, 0, 20530, 0}, '{17209, 17779, 10265, 0}, '{17209, 17779, -10265, 0},
        '{17209, 0, -20530, 0}, '{17209, -17779, -10265, 0}, '{17209, -17779, 10265, 0},
        '{14746, 0, 17594, 0}, '{14750, 13755, 10971, 0}, '{14750, 17157, -3912, 0},
        '{14753, 7636, -15856, 0}, '{14753, -7636, -15856, 0},
        '{14750, -17157, -3912, 0}, '{14750, -13755, 10971, 0},
        '{12907, 5892, 14225, 0}, '{12907, 14225, 5892, 0}, '{12907, 14225, -5892, 0},
        '{12907, 5892, -14225, 0}, '{12907, -5892, -14225, 0},
        '{12907, -14225, -5892, 0}, '{12907, -14225, 5892, 0}, '{12907, -5892, 14225, 0},
        '{30036, 27241, 0, 8640}, '{62891, 27241, 0, -24049}, '{30036, -27241, 0, 8640},
        '{62891, -27241, 0, -24049}, '{23232, 0, 0, 15409}, '{23232, 0, 0, 15409},
        '{9351, 9771, 18751, 9771}, '{9351, 9771, -18751, 9771},
        '{9351, -9771, 18751, 9771}, '{9351, -9771, -18751, 9771},
        '{9351, 9771, 18751, -9771}, '{9351, 9771, -18751, -9771},
        '{9351, -9771, 18751, -9771}, '{9351, -9771, -18751, -9771},
        '{11616, 0, 0, 9448}, '{11616, 5553, 0, 7643}, '{11616, 8985, 0, 2919},
        '{11616, 8985, 0, -2919}, '{11616, 5553, 0, -7643}, '{11616, 0, 0, -9448},
        '{11616, -5553, 0, 7643}, '{11616, -8985, 0, 2919}, '{11616, -8985, 0, -2919},
        '{11616, -5553, 0, -7643}, '{11616, 0, 12685, 7505}, '{11616, 7138, 12685, 2319},
        '{11616, 4411, 12685, -6072}, '{11616, -7138, 12685, 2319},
        '{11616, -4411, 12685, -6072}, '{11616, 4411, -12685, 6072},
        '{11616, 7138, -12685, -2319}, '{11616, 0, -12685, -7505},
        '{11616, -7138, -12685, -2319}, '{11616, -4411, -12685, 6072},
        '{11957, 0, 0, 14731}, '{11957, 0, 0, 14731}, '{14978, 0, 11340, 10024},
        '{18827, 19974, 11340, 1062}, '{18827, -19974, 11340, 1062},
        '{26114, 12344, 11340, -13440}, '{26114, -12344, 11340, -13440},
        '{14978, 0, -11340, 10024}, '{18827, 19974, -11340, 1062},
        '{18827, -19974, -11340, 1062}, '{26114, 12344, -11340, -13440},
        '{26114, -12344, -11340, -13440}
    };

    // layouts that actually emit speaker samples
    localparam logic [3:0] DECODING_LAYS [11] = '{
        LAY_MONO, LAY_TRIANGLE, LAY_SQUARE, LAY_PENTAGON, LAY_HEXAGON, LAY_HEPTAGON,
        LAY_OCTAGON, LAY_OCTA, LAY_CUBE, LAY_DODECA, LAY_ICOSA
    };
    localparam logic [3:0] SWEEP_LAYS [7] = '{
        LAY_TRIANGLE, LAY_PENTAGON, LAY_HEXAGON, LAY_HEPTAGON, LAY_OCTAGON,
        LAY_CUBE, LAY_ICOSA
    };
    localparam logic [1:0] NORMS [3] = '{NORM_N3D, NORM_SN3D, NORM_FUMA};

    // all inputs known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // w_sample, x_sample, y_sample, z_sample
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // speaker_index[4:0], speaker_sample[28:5], padding
    logic        m_tlast;          // last_speaker

    // bench copy of the two registers, at their reset values
    logic [3:0] cur_layout = LAY_SQUARE;
    logic [1:0] cur_norm   = NORM_N3D;

    spk_out_t speaker_due_q [$];
    int       fail_cnt    = 0;
    int       idle_cycles = 0;
    int       rx_left     = 0;
    bit       tx_gap_en   = 1'b1;
    bit       rx_stall_en = 1'b1;

    ambisonic_speaker_decoder_top #(
        .MAX_SPEAKERS (MAX_SPK),
        .SAMPLE_BITS  (SMP_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model: scale each channel by its gain, take the dot product
    // with every row of the layout, round and saturate. Results are queued
    // in speaker order, last flag on the final one.
    // ------------------------------------------------------------------
    function automatic void decode_speakers(input bformat_t b);
        smp_t     raw [4];
        longint   scl [4];
        longint   acc;
        longint   y;
        int       count;
        int       row;
        spk_out_t r;
        raw[0] = b.w;
        raw[1] = b.x;
        raw[2] = b.y;
        raw[3] = b.z;
        for (int c = 0; c < 4; c++)
            scl[c] = (longint'(raw[c]) * IN_GAIN[cur_norm][c] + 32768) >>> 16;
        count = ROW_COUNT[cur_layout];
        if (count > MAX_SPK)
            count = MAX_SPK;
        for (int k = 0; k < count; k++) begin
            row = ROW_FIRST[cur_layout] + k;
            acc = 0;
            // 2-D layouts (octahedron included) ignore Z
            for (int c = 0; c < CHAN_USED[cur_layout]; c++)
                acc += longint'(COEF[row][c]) * scl[c];
            y = (acc + 32768) >>> 16;
            if (y > longint'(SMP_MAX))
                y = longint'(SMP_MAX);
            if (y < longint'(SMP_MIN))
                y = longint'(SMP_MIN);
            r.idx  = 5'(k);
            r.smp  = smp_t'(y);
            r.last = (k == count - 1);
            speaker_due_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int tx_gap();
        if (!tx_gap_en || $urandom_range(0, 2) != 0)
            return 0;
        return gap_len();
    endfunction

    // extremes, values near zero, and the full range
    function automatic smp_t rand_smp();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return smp_t'(int'($urandom_range(0, 2000)) - 1000);
            default: return smp_t'($urandom);
        endcase
    endfunction

    function automatic bformat_t rand_bformat();
        bformat_t b;
        b.w = rand_smp();
        b.x = rand_smp();
        b.y = rand_smp();
        b.z = rand_smp();
        return b;
    endfunction

    function automatic bformat_t mk_bformat(input smp_t w, input smp_t x,
                                            input smp_t y, input smp_t z);
        bformat_t b;
        b.w = w;
        b.x = x;
        b.y = y;
        b.z = z;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left just after a falling edge,
    // so drives land ahead of the rising edge that samples them.
    // ------------------------------------------------------------------
    // One input transaction. s_tvalid stays high on exit so that a
    // back-to-back transaction needs no second drive in the same step;
    // wait_results lowers it when the stream pauses.
    task automatic send_bformat(input bformat_t b);
        int gap;
        gap = tx_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        decode_speakers(b);
        @(negedge aclk);
    endtask

    // Stop sending and wait for every due speaker result, then let the
    // pipeline settle (layouts with no output leave no trace in the queue).
    task automatic wait_results(input int settle);
        s_tvalid <= 1'b0;
        while (speaker_due_q.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Each write lowers cfg_wr_en again before it returns, so that
    // back-to-back writes never drive cfg_wr_en twice in one step.
    task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_LAYOUT)
            cur_layout = val;
        else
            cur_norm = val[1:0];  // upper bits of the field are dropped
        @(negedge aclk);
    endtask

    // registers change only with the block idle
    task automatic apply_config(input logic [3:0] lay, input logic [3:0] nrm);
        wait_results(SETTLE_CYCLES);
        write_reg(REG_LAYOUT, lay);
        write_reg(REG_NORM, nrm);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure on m_tready
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_left != 0)
            rx_left--;
        else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
            rx_left = gap_len() - 1;
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Checker: each result transaction against the oldest one due
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_speakers
        spk_out_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (speaker_due_q.size() == 0) begin
                $error("speaker transaction with none due: speaker_index %0d speaker_sample %0d",
                       m_tdata[4:0], $signed(m_tdata[5 +: SMP_W]));
                fail_cnt++;
            end else begin
                due = speaker_due_q.pop_front();
                if (m_tdata[4:0] !== due.idx) begin
                    $error("speaker_index: expected %0d, got %0d", due.idx, m_tdata[4:0]);
                    fail_cnt++;
                end
                if (m_tdata[5 +: SMP_W] !== due.smp) begin
                    $error("speaker_sample: expected %0d, got %0d",
                           due.smp, $signed(m_tdata[5 +: SMP_W]));
                    fail_cnt++;
                end
                if (m_tlast !== due.last) begin
                    $error("last_speaker: expected %0d, got %0d", due.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** ambisonic_speaker_decoder_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset leaves square layout with N3D gains; no register is written here.
    task automatic test_reset_values();
        send_bformat(mk_bformat('0, '0, '0, '0));
        send_bformat(mk_bformat(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
        send_bformat(mk_bformat(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN));
        send_bformat(mk_bformat(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN));
    endtask

    // Saturation, the layouts with no output, spare codes, and every
    // decoding layout other than square once.
    task automatic test_layout_sweep();
        // octahedron W row near 1.0 with Furse-Malham W gain: clips both ways
        apply_config(LAY_OCTA, NORM_FUMA);
        send_bformat(mk_bformat(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
        send_bformat(mk_bformat(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN));
        // no decode matrix: transactions swallowed, nothing comes out
        apply_config(LAY_STEREO, NORM_N3D);
        send_bformat(mk_bformat(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN));
        apply_config(LAY_TETRA, NORM_SN3D);
        send_bformat(rand_bformat());
        apply_config(LAY_SPARE_LO, NORM_FUMA);
        send_bformat(rand_bformat());
        apply_config(LAY_SPARE_HI, NORM_N3D);
        send_bformat(rand_bformat());
        // spare normalisation code behaves as unity
        apply_config(LAY_MONO, NORM_SPARE);
        send_bformat(mk_bformat(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX));
        // largest layout, twenty speakers
        apply_config(LAY_DODECA, NORM_SN3D);
        send_bformat(mk_bformat(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN));
        send_bformat(rand_bformat());
        foreach (SWEEP_LAYS[i]) begin
            apply_config(SWEEP_LAYS[i], NORMS[i % 3]);
            send_bformat(rand_bformat());
        end
    endtask

    // Random phases, each with its own settings. Phase 0 runs with no
    // idling on either side; phase 1 and some others hold the sender off
    // mid-phase until every result is out.
    task automatic test_random_phases();
        int          decoded;
        int          n;
        logic [3:0]  lay;
        logic [3:0]  nrm;
        bit          quiet;
        bit          hold_off;
        decoded = 0;
        for (int phase = 0; decoded < RANDOM_ITEMS; phase++) begin
            if ($urandom_range(0, 7) == 0)
                lay = 4'($urandom_range(0, 15));
            else
                lay = DECODING_LAYS[$urandom_range(0, 10)];
            // upper bits of the normalisation write are don't-care
            nrm = 4'($urandom_range(0, 15));
            apply_config(lay, nrm);
            quiet       = (phase == 0) || ($urandom_range(0, 4) == 0);
            hold_off    = (phase == 1) || ($urandom_range(0, 5) == 0);
            tx_gap_en   = !quiet;
            rx_stall_en = !quiet;
            n = $urandom_range(8, 30);
            for (int i = 0; i < n; i++) begin
                if (hold_off && i == n / 2)
                    wait_results(1);
                send_bformat(rand_bformat());
            end
            if (ROW_COUNT[lay] != 0)
                decoded += n;
        end
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_layout_sweep();
        test_random_phases();
        wait_results(20);
        if (fail_cnt == 0 && speaker_due_q.size() == 0)
            $display("** ambisonic_speaker_decoder_top: PASSED **");
        else
            $display("** ambisonic_speaker_decoder_top: FAILED **");
        $finish;
    end

endmodule

// ===== ambisonic_speaker_decoder_top.f =====
+incdir+hdl
hdl/asd_pkg.sv
hdl/asd_front.sv
hdl/asd_queue.sv
hdl/asd_back.sv
hdl/ambisonic_speaker_decoder_top.sv
bench/testbench.sv
